[rtl/masked_byte_signature_scanner_assert.svh]
// Assertion macros shared by the scanner checker files.
`ifndef MASKED_BYTE_SIGNATURE_SCANNER_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_SCANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MSSCAN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MSSCAN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/msscan_pkg.sv]
// Types, constants and test function for the masked byte signature scanner.
package msscan_pkg;

    // Pattern geometry fixed by the register layout
    localparam int PAT_BYTES   = 8;
    localparam int PAT_BITS_W  = 64;
    localparam int TESTS_W     = 24;
    localparam int CODE_W      = 3;
    localparam int LEN_W       = 4;
    localparam int ALIGN_W     = 2;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Per-byte test codes; anything else always fails
    typedef enum logic [CODE_W-1:0] {
        TEST_ANY = 3'd0,
        TEST_EQ  = 3'd1,
        TEST_NE  = 3'd2,
        TEST_LT  = 3'd3,
        TEST_GT  = 3'd4
    } test_code_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 3'd0,
        CFG_PATTERN_TESTS  = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_ALIGN_LOG2     = 3'd3,
        CFG_FIRST_ONLY     = 3'd4
    } cfg_reg_t;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } scan_item_t;

    // Result item
    typedef struct packed {
        logic               match_here;
        logic [COUNT_W-1:0] match_offset;
        logic [COUNT_W-1:0] match_count;
        logic               stream_done;
    } result_item_t;

    // Configuration write
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // One byte test: data byte b against pattern byte p
    function automatic logic byte_test_pass(
        input logic [7:0]        b,
        input logic [7:0]        p,
        input logic [CODE_W-1:0] code
    );
        logic pass;
        case (code)
            TEST_ANY: pass = 1'b1;
            TEST_EQ:  pass = (b == p);
            TEST_NE:  pass = (b != p);
            TEST_LT:  pass = (b < p);
            TEST_GT:  pass = (b > p);
            default:  pass = 1'b0;
        endcase
        return pass;
    endfunction

endpackage

[rtl/msscan_stream_if.sv]
// Valid/ready channel interface carrying one payload item per handshake.
interface msscan_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/masked_byte_signature_scanner.sv]
// Masked byte signature scanner: windowed per-byte pattern test over a byte stream.
//
// Channels: stream carries one region byte per item (data_byte, last_byte);
// report carries result items (match_here, match_offset, match_count,
// stream_done); cfg writes registers 0..4 (index, data), always ready.
// A result is produced when a reported match ends at a byte, or for the
// region's last byte, which carries the final count and sets stream_done.
// An accepted item sits in the input register, is tested there against the
// byte window, and its result is then captured in the result register.
// Throughput: one byte per cycle except in the stall below; the window compare,
// the offset subtract and the count increment all sit between the input and
// result registers. Stall: while a result waits on report, bytes that yield
// no result keep entering and finishing, one per cycle; a byte that yields
// one waits in the input register and stream.ready drops.
// Reset: config returns to its defaults (length 4), offset, count, fill
// and the first-only stop flag clear; both registers empty.
module masked_byte_signature_scanner #(
    parameter int WINDOW_BYTES = 8,
    parameter int OFFSET_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    msscan_stream_if.sink         stream,
    msscan_stream_if.source       report,
    msscan_stream_if.sink         cfg
);
    import msscan_pkg::*;

    localparam int CAP    = (WINDOW_BYTES < PAT_BYTES) ? WINDOW_BYTES : PAT_BYTES;
    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
    localparam int IDX_W  = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
    localparam int CMP_W  = ((FILL_W > LEN_W) ? FILL_W : LEN_W) + 1;

    // Configuration registers
    logic [PAT_BITS_W-1:0] pat_bytes_reg;
    logic [TESTS_W-1:0]    pat_tests_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [ALIGN_W-1:0]    align_reg;
    logic                  first_only_reg;

    // Input register
    logic                  s1_valid_reg;
    logic [7:0]            s1_byte_reg;
    logic                  s1_last_reg;

    // Scan state
    logic [7:0]             win_reg  [WINDOW_BYTES];
    logic [7:0]             win_next [WINDOW_BYTES];
    logic [FILL_W-1:0]      fill_reg, fill_next, fill_inc;
    logic [OFFSET_BITS-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0]     total_reg, total_next, total_hit;
    logic                   stopped_reg, stopped_next;

    // Result register
    logic                   out_valid_reg;
    result_item_t           out_item_reg;

    // Datapath
    logic [LEN_W-1:0]       len_eff;
    logic [OFFSET_BITS-1:0] start_off;
    logic [2:0]             align_mask;
    logic                   fill_ok, aligned, all_pass, hit, report_now, produce;
    logic                   out_free, advance;

    assign cfg.ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg  <= '0;
            pat_tests_reg  <= '0;
            pat_len_reg    <= LEN_W'(4);
            align_reg      <= '0;
            first_only_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                CFG_PATTERN_BYTES:  pat_bytes_reg  <= cfg.payload.data[PAT_BITS_W-1:0];
                CFG_PATTERN_TESTS:  pat_tests_reg  <= cfg.payload.data[TESTS_W-1:0];
                CFG_PATTERN_LENGTH: pat_len_reg    <= cfg.payload.data[LEN_W-1:0];
                CFG_ALIGN_LOG2:     align_reg      <= cfg.payload.data[ALIGN_W-1:0];
                CFG_FIRST_ONLY:     first_only_reg <= cfg.payload.data[0];
                default:            ;
            endcase
        end
    end

    // Effective pattern length, clamped to 1..CAP
    always_comb
    begin
        if (pat_len_reg == '0)
            len_eff = LEN_W'(1);
        else if (32'(pat_len_reg) > CAP)
            len_eff = LEN_W'(CAP);
        else
            len_eff = pat_len_reg;
    end

    // Window shift, newest byte at entry 0
    always_comb
    begin
        win_next[0] = s1_byte_reg;
        for (int i = 1; i < WINDOW_BYTES; i++)
            win_next[i] = win_reg[i-1];
    end

    assign fill_inc = (32'(fill_reg) < WINDOW_BYTES) ? fill_reg + FILL_W'(1) : fill_reg;
    assign fill_ok  = CMP_W'(fill_inc) >= CMP_W'(len_eff);

    // Candidate start offset and alignment check on its low bits
    assign start_off  = idx_reg - OFFSET_BITS'(len_eff - LEN_W'(1));
    assign align_mask = (3'b001 << align_reg) - 3'b001;
    assign aligned    = (start_off[2:0] & align_mask) == 3'b000;

    // Parallel byte tests over the active pattern bytes
    always_comb
    begin
        logic [LEN_W-1:0] sel;
        all_pass = 1'b1;
        for (int k = 0; k < CAP; k++)
        begin
            sel = len_eff - LEN_W'(1) - LEN_W'(k);
            if (LEN_W'(k) < len_eff)
            begin
                if (!byte_test_pass(win_next[sel[IDX_W-1:0]],
                                    pat_bytes_reg[8*k +: 8],
                                    pat_tests_reg[CODE_W*k +: CODE_W]))
                    all_pass = 1'b0;
            end
        end
    end

    assign hit        = fill_ok && aligned && all_pass;
    assign report_now = hit && !stopped_reg;
    assign produce    = report_now || s1_last_reg;
    assign total_hit  = (hit && (total_reg != '1)) ? total_reg + COUNT_W'(1) : total_reg;

    // Handshake: result register frees when empty or taken
    assign out_free     = !out_valid_reg || report.ready;
    assign advance      = s1_valid_reg && (!produce || out_free);
    assign stream.ready = !s1_valid_reg || advance;
    assign report.valid   = out_valid_reg;
    assign report.payload = out_item_reg;

    // Next scan state; a region's last byte clears it
    always_comb
    begin
        if (s1_last_reg)
        begin
            fill_next    = '0;
            idx_next     = '0;
            total_next   = '0;
            stopped_next = 1'b0;
        end
        else
        begin
            fill_next    = fill_inc;
            idx_next     = idx_reg + OFFSET_BITS'(1);
            total_next   = total_hit;
            stopped_next = stopped_reg || (report_now && first_only_reg);
        end
    end

    // Control and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            stopped_reg   <= 1'b0;
            for (int i = 0; i < WINDOW_BYTES; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (stream.valid && stream.ready)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance && produce)
                out_valid_reg <= 1'b1;
            else if (report.ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                fill_reg    <= fill_next;
                idx_reg     <= idx_next;
                total_reg   <= total_next;
                stopped_reg <= stopped_next;
                for (int i = 0; i < WINDOW_BYTES; i++)
                    win_reg[i] <= win_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            s1_byte_reg <= stream.payload.data_byte;
            s1_last_reg <= stream.payload.last_byte;
        end
        if (advance && produce)
        begin
            out_item_reg.match_here   <= report_now;
            out_item_reg.match_offset <= report_now ? COUNT_W'(start_off) : '0;
            out_item_reg.match_count  <= total_hit;
            out_item_reg.stream_done  <= s1_last_reg;
        end
    end

endmodule

[rtl/msscan_checker.sv]
// Port-level checker for the scanner and its bind to the top level.
`include "masked_byte_signature_scanner_assert.svh"

module msscan_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        match_here,
    input logic [31:0] match_offset,
    input logic [31:0] match_count,
    input logic        stream_done
);
    // A stalled result stays offered
    `MSSCAN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    // Only matches and region ends make results
    `MSSCAN_ASSERT_NOW(a_out_cause, out_valid, match_here || stream_done, "result with no cause")
    // No reported match means a zero offset
    `MSSCAN_ASSERT_NOW(a_off_zero, out_valid && !match_here, match_offset == 32'd0, "offset without match")
    // A reported match is always counted
    `MSSCAN_ASSERT_NOW(a_cnt_nz, out_valid && match_here, match_count != 32'd0, "match not counted")
endmodule

bind masked_byte_signature_scanner msscan_checker u_msscan_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (report.valid),
    .out_ready    (report.ready),
    .match_here   (report.payload.match_here),
    .match_offset (report.payload.match_offset),
    .match_count  (report.payload.match_count),
    .stream_done  (report.payload.stream_done)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Scanner testbench: scoreboard package with a bit-exact match predictor, then the tb top.
package scan_check_pkg;
    import msscan_pkg::*;

    localparam int WINDOW_BYTES = 8;

    // Predicts scanner results and checks them in order
    class match_scoreboard;
        logic [63:0]  pat_bytes;
        logic [23:0]  pat_tests;
        logic [3:0]   pat_len;
        logic [1:0]   align_log2;
        logic         first_only;
        logic [7:0]   window [WINDOW_BYTES];
        logic [31:0]  byte_index;
        logic [31:0]  found_total;
        logic         stopped;
        int unsigned  fill;
        result_item_t expected_q [$];
        int unsigned  failures;

        function new();
            pat_bytes   = '0;
            pat_tests   = '0;
            pat_len     = 4'd4;
            align_log2  = '0;
            first_only  = 1'b0;
            byte_index  = '0;
            found_total = '0;
            stopped     = 1'b0;
            fill        = 0;
            failures    = 0;
            foreach (window[i]) window[i] = 8'h00;
        endfunction

        // Pattern length as the block applies it: 0 acts as 1, clipped to window
        function int unsigned used_len();
            int unsigned len;
            len = pat_len;
            if (len == 0) len = 1;
            if (len > PAT_BYTES) len = PAT_BYTES;
            if (len > WINDOW_BYTES) len = WINDOW_BYTES;
            return len;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN_BYTES:  pat_bytes  = data;
                CFG_PATTERN_TESTS:  pat_tests  = data[TESTS_W-1:0];
                CFG_PATTERN_LENGTH: pat_len    = data[LEN_W-1:0];
                CFG_ALIGN_LOG2:     align_log2 = data[ALIGN_W-1:0];
                CFG_FIRST_ONLY:     first_only = data[0];
                default: ;
            endcase
        endfunction

        // Accepted byte: shift window, test aligned start, queue any result
        function void note_item(scan_item_t item);
            int unsigned  len;
            logic [31:0]  start;
            logic         hit;
            logic         report;
            logic [7:0]   b;
            logic [7:0]   p;
            logic [2:0]   code;
            result_item_t res;
            len = used_len();
            for (int i = WINDOW_BYTES - 1; i > 0; i--) window[i] = window[i - 1];
            window[0] = item.data_byte;
            if (fill < WINDOW_BYTES) fill++;

            start = byte_index - 32'(len - 1);
            hit   = 1'b0;
            if (fill >= len && (start & ((32'd1 << align_log2) - 32'd1)) == 32'd0)
            begin
                hit = 1'b1;
                // pattern byte 0 lines up with the oldest byte of the candidate
                for (int k = 0; k < len; k++)
                begin
                    b    = window[len - 1 - k];
                    p    = pat_bytes[8*k +: 8];
                    code = pat_tests[3*k +: 3];
                    case (code)
                        TEST_ANY: ;
                        TEST_EQ:  if (b != p) hit = 1'b0;
                        TEST_NE:  if (b == p) hit = 1'b0;
                        TEST_LT:  if (!(b < p)) hit = 1'b0;
                        TEST_GT:  if (!(b > p)) hit = 1'b0;
                        default:  hit = 1'b0;
                    endcase
                end
            end

            // every match counts; reporting stops after the first in first-only mode
            report = 1'b0;
            if (hit)
            begin
                if (found_total != 32'hFFFF_FFFF) found_total++;
                if (!stopped)
                begin
                    report = 1'b1;
                    if (first_only) stopped = 1'b1;
                end
            end

            if (report || item.last_byte)
            begin
                res.match_here   = report;
                res.match_offset = report ? start : 32'd0;
                res.match_count  = found_total;
                res.stream_done  = item.last_byte;
                expected_q.push_back(res);
            end

            byte_index++;
            if (item.last_byte)
            begin
                byte_index  = '0;
                found_total = '0;
                stopped     = 1'b0;
                fill        = 0;
            end
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: %p", got);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.match_here !== want.match_here)
            begin
                $error("match_here expected %0d actual %0d", want.match_here, got.match_here);
                failures++;
            end
            if (got.match_offset !== want.match_offset)
            begin
                $error("match_offset expected %0d actual %0d", want.match_offset, got.match_offset);
                failures++;
            end
            if (got.match_count !== want.match_count)
            begin
                $error("match_count expected %0d actual %0d", want.match_count, got.match_count);
                failures++;
            end
            if (got.stream_done !== want.stream_done)
            begin
                $error("stream_done expected %0d actual %0d", want.stream_done, got.stream_done);
                failures++;
            end
        endfunction
    endclass

endpackage

module tb;
    import msscan_pkg::*;
    import scan_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam logic [CODE_W-1:0]    TEST_FAIL_LO = 3'd5;
    localparam logic [CODE_W-1:0]    TEST_FAIL_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    msscan_stream_if #(.payload_t(scan_item_t))   stream_ch ();
    msscan_stream_if #(.payload_t(result_item_t)) report_ch ();
    msscan_stream_if #(.payload_t(cfg_write_t))   cfg_ch ();

    match_scoreboard sb;
    bit              src_idle_on = 1'b1;
    bit              snk_idle_on = 1'b1;
    int unsigned     idle_cycles = 0;
    int unsigned     region_pos  = 0;
    int unsigned     region_left = 0;
    logic [7:0]      seq_q [$];
    logic [7:0]      region_q [$];

    masked_byte_signature_scanner u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .report (report_ch),
        .cfg    (cfg_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Handshake monitor feeding the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.payload.index, cfg_ch.payload.data);
            if (stream_ch.valid && stream_ch.ready)
                sb.note_item(stream_ch.payload);
            if (report_ch.valid && report_ch.ready)
                sb.check_result(report_ch.payload);
        end
    end

    // Watchdog: too long with no item moving on any channel
    always @(posedge clk)
    begin
        if ((stream_ch.valid && stream_ch.ready) || (report_ch.valid && report_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result sink: random stall before each result
    initial
    begin : report_sink
        int unsigned stall;
        report_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = snk_idle_on ? $urandom_range(0, 5) : 0;
            if (stall != 0)
            begin
                report_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            report_ch.ready <= 1'b1;
            do @(posedge clk); while (!report_ch.valid);
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic l);
        int unsigned gap;
        scan_item_t  item;
        gap = src_idle_on ? $urandom_range(0, 5) : 0;
        item.data_byte = d;
        item.last_byte = l;
        if (gap != 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid   <= 1'b1;
        stream_ch.payload <= item;
        do @(posedge clk); while (!stream_ch.ready);
    endtask

    // Sends region_q as one whole region
    task automatic send_region();
        foreach (region_q[i]) send_byte(region_q[i], i == region_q.size() - 1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_write_t w;
        w.index = idx;
        w.data  = data;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= w;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Full register load; an unused index is written too and must change nothing
    task automatic write_config(input logic [63:0] pbytes, input logic [23:0] ptests,
                                input logic [3:0] plen, input logic [1:0] palign,
                                input logic only_first);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        write_reg(CFG_PATTERN_BYTES, pbytes);
        write_reg(CFG_PATTERN_TESTS, 64'(ptests));
        write_reg(CFG_PATTERN_LENGTH, 64'(plen));
        write_reg(CFG_ALIGN_LOG2, 64'(palign));
        write_reg(CFG_FIRST_ONLY, 64'(only_first));
        cfg_ch.valid <= 1'b0;
        seq_q.delete();
    endtask

    // Stop sending, let the monitor note the last item, wait for every
    // result, let the pipeline run dry
    task automatic settle();
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random regions, seeded with aligned pattern occurrences (some broken)
    task automatic run_items(input int unsigned n);
        int unsigned amask;
        int unsigned len;
        logic [7:0]  d;
        logic [7:0]  p;
        logic [2:0]  code;
        repeat (n)
        begin
            if (region_left == 0)
            begin
                region_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 16);
                region_pos = 0;
                seq_q.delete();
            end
            len   = sb.used_len();
            amask = (1 << sb.align_log2) - 1;
            if (seq_q.size() == 0 && (region_pos & amask) == 0 && $urandom_range(0, 2) == 0)
            begin
                for (int k = 0; k < len; k++)
                begin
                    p    = sb.pat_bytes[8*k +: 8];
                    code = sb.pat_tests[3*k +: 3];
                    case (code)
                        TEST_EQ: d = p;
                        TEST_NE: d = p ^ 8'($urandom_range(1, 255));
                        TEST_LT: d = (p == 8'h00) ? 8'($urandom) : 8'($urandom_range(0, p - 1));
                        TEST_GT: d = (p == 8'hFF) ? 8'($urandom) : 8'($urandom_range(p + 1, 255));
                        default: d = 8'($urandom);
                    endcase
                    seq_q.push_back(d);
                end
                if ($urandom_range(0, 4) == 0)
                    seq_q[$urandom_range(0, len - 1)] = 8'($urandom);
            end
            if (seq_q.size() != 0)
                d = seq_q.pop_front();
            else
                d = 8'($urandom);
            send_byte(d, region_left == 1);
            region_pos++;
            region_left--;
        end
    endtask

    // Main sequence
    initial
    begin
        logic [63:0] pbytes;
        logic [23:0] ptests;
        logic [3:0]  plen;
        logic [1:0]  palign;
        logic        only_first;
        int unsigned w;

        sb = new();
        rst_n             <= 1'b0;
        stream_ch.valid   <= 1'b0;
        stream_ch.payload <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.payload    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings (all don't care, length 4): overlapping matches,
        // a region shorter than the pattern, a one-byte region
        region_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55};
        send_region();
        region_q = '{8'h12, 8'h34};
        send_region();
        region_q = '{8'hFF};
        send_region();
        settle();

        // Every test code at byte extremes, first-only: second match counted
        // only, and it lands on the last byte
        write_config(64'h00_00_FF_00_FF,
                     {9'd0, TEST_ANY, TEST_GT, TEST_LT, TEST_NE, TEST_EQ},
                     4'd5, 2'd0, 1'b1);
        region_q = '{8'hFF, 8'h01, 8'hFE, 8'h01, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h01, 8'h80};
        send_region();
        settle();

        // Length 0 acts as 1; all codes fail; widest alignment
        write_config('1, {PAT_BYTES{TEST_FAIL_HI}}, 4'd0, 2'd3, 1'b0);
        region_q = '{8'hFF, 8'h00, 8'hFF};
        send_region();
        settle();

        // Random phases; regions may run across a register change
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int k = 0; k < PAT_BYTES; k++)
            begin
                w = $urandom_range(0, 5);
                pbytes[8*k +: 8] = (w == 0) ? 8'h00 : (w == 1) ? 8'hFF : 8'($urandom);
                w = $urandom_range(0, 99);
                if (w < 30)      ptests[3*k +: 3] = TEST_ANY;
                else if (w < 65) ptests[3*k +: 3] = TEST_EQ;
                else if (w < 75) ptests[3*k +: 3] = TEST_NE;
                else if (w < 85) ptests[3*k +: 3] = TEST_LT;
                else if (w < 95) ptests[3*k +: 3] = TEST_GT;
                else             ptests[3*k +: 3] = 3'($urandom_range(TEST_FAIL_LO, TEST_FAIL_HI));
            end
            case (ph)
                0:       plen = 4'd8;
                1:       plen = 4'd1;
                2:       plen = 4'd15;
                3:       plen = 4'd0;
                default: plen = 4'($urandom_range(1, 8));
            endcase
            palign     = (ph == 0) ? 2'd3 : (ph == 1) ? 2'd0 : 2'($urandom_range(0, 3));
            only_first = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            // idle patterns: both, sender only steady, receiver only steady, neither
            src_idle_on = (ph % 4 == 0) || (ph % 4 == 2);
            snk_idle_on = (ph % 4 == 0) || (ph % 4 == 1);
            write_config(pbytes, ptests, plen, palign, only_first);
            run_items(PHASE_ITEMS);
            settle();
        end

        if (sb.failures == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
